// ===== src/rsmf_pkg.sv =====
`timescale 1ns / 1ps
// rsmf_pkg: shared constants, types and helpers of the rgb sliding median filter
// depends on nothing; used by every module of the block
package rsmf_pkg;

   localparam int WINDOW_COLS = 3;
   localparam int WINDOW_ROWS = 3;
   localparam int WIN_SIZE    = WINDOW_COLS * WINDOW_ROWS;
   localparam int MEDIAN_IDX  = WIN_SIZE / 2;
   localparam int CHANNELS    = 3;

   localparam int PIX_W  = 8;
   localparam int POS_W  = $clog2(WIN_SIZE + 1);
   localparam int RANK_W = $clog2(WIN_SIZE + 1);
   localparam int CNT_W  = 12;
   localparam int DIM_W  = 13;
   localparam int CSR_IDX_W = 1;

   localparam logic [DIM_W-1:0] MAX_DIM   = 13'd4096;
   localparam logic [DIM_W-1:0] DIM_RESET = 13'd256;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef pixel_type [WIN_SIZE-1:0] window_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic done;
      logic frame_end;
   } win_status_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > MAX_DIM) begin
         r = MAX_DIM;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== src/rgb_sliding_median_filter_core.sv =====
`timescale 1ns / 1ps
// rgb_sliding_median_filter_core: top level of the rgb 3x3 sliding median filter
// depends on rsmf_pkg, rsmf_window and rsmf_median
//
// Usage:
// - req_ carries window pixels in filter read order: at output column 0 the
//   full window row-major, otherwise one new column top to bottom.
// - rsp_ carries one median pixel per completed window update; rsp_tlast
//   marks the last pixel of a frame.
// - csr_ writes image_width (index 0) and image_height (index 1); always
//   ready, to be written only while no pixel is in flight.
// - Path: the pixel that completes the window enters the input register;
//   the window update and rank-select median result are then loaded into
//   the result register, which drives rsp_.
// - Throughput: one pixel per cycle while the output is not stalled; a result
//   every 3 pixels inside a row and every 9 pixels at column 0.
// - Reset clears the window to zero, the counters and load position, and
//   sets width and height to 256.
// - When rsp_tready is low the output register holds; the input register
//   still takes one more pixel, then req_tready drops until the result moves.
module rgb_sliding_median_filter_core (
   input  logic                               clock,
   input  logic                               reset,
   // in_red, in_green, in_blue from bit 0 up
   input  logic [23:0]                        req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // median_red, median_green, median_blue from bit 0 up
   output logic [23:0]                        rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rsmf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rsmf_pkg::DIM_W-1:0]         csr_wdata
);

   logic [rsmf_pkg::DIM_W-1:0]   width_ff;
   logic [rsmf_pkg::DIM_W-1:0]   height_ff;
   logic [rsmf_pkg::DIM_W-1:0]   width_eff;
   logic [rsmf_pkg::DIM_W-1:0]   height_eff;

   logic                         s1_valid_ff;
   logic [23:0]                  s1_data_ff;
   logic                         s1_go;

   logic                         rsp_valid_ff;
   logic [23:0]                  rsp_data_ff;
   logic                         rsp_last_ff;

   rsmf_pkg::pixel_type          pix [rsmf_pkg::CHANNELS];
   rsmf_pkg::window_type         win_next [rsmf_pkg::CHANNELS];
   rsmf_pkg::pixel_type          med [rsmf_pkg::CHANNELS];
   rsmf_pkg::win_status_type     status;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rsmf_pkg::DIM_RESET;
         height_ff <= rsmf_pkg::DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         case (rsmf_pkg::csr_index_type'(csr_index))
            rsmf_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            rsmf_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign width_eff  = rsmf_pkg::eff_dim(width_ff);
   assign height_eff = rsmf_pkg::eff_dim(height_ff);

   // input register
   assign s1_go      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_data_ff <= req_tdata;
      end
   end

   assign pix[0] = s1_data_ff[7:0];
   assign pix[1] = s1_data_ff[15:8];
   assign pix[2] = s1_data_ff[23:16];

   rsmf_window u_window (
      .clock    (clock),
      .reset    (reset),
      .step     (s1_go),
      .pix      (pix),
      .width    (width_eff),
      .height   (height_eff),
      .win_next (win_next),
      .status   (status)
   );

   for (genvar k = 0; k < rsmf_pkg::CHANNELS; k++) begin : g_median
      rsmf_median u_median (
         .win    (win_next[k]),
         .median (med[k])
      );
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= status.done;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && status.done) begin
         rsp_data_ff <= {med[2], med[1], med[0]};
         rsp_last_ff <= status.frame_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== src/rsmf_median.sv =====
`timescale 1ns / 1ps
// rsmf_median: rank-select median of one channel's window, purely combinational
// depends on rsmf_pkg
module rsmf_median (
   input  rsmf_pkg::window_type win,
   output rsmf_pkg::pixel_type  median
);

   logic [rsmf_pkg::RANK_W-1:0] lt_cnt [rsmf_pkg::WIN_SIZE];
   logic [rsmf_pkg::RANK_W-1:0] le_cnt [rsmf_pkg::WIN_SIZE];

   // count smaller and not-larger elements for every entry
   always_comb begin
      for (int i = 0; i < rsmf_pkg::WIN_SIZE; i++) begin
         lt_cnt[i] = '0;
         le_cnt[i] = '0;
         for (int j = 0; j < rsmf_pkg::WIN_SIZE; j++) begin
            lt_cnt[i] = lt_cnt[i] + rsmf_pkg::RANK_W'(win[j] <  win[i]);
            le_cnt[i] = le_cnt[i] + rsmf_pkg::RANK_W'(win[j] <= win[i]);
         end
      end
   end

   // entry whose rank span covers the middle index
   always_comb begin
      median = '0;
      for (int i = 0; i < rsmf_pkg::WIN_SIZE; i++) begin
         if ((lt_cnt[i] <= rsmf_pkg::RANK_W'(rsmf_pkg::MEDIAN_IDX)) &&
             (le_cnt[i] >  rsmf_pkg::RANK_W'(rsmf_pkg::MEDIAN_IDX))) begin
            median = win[i];
         end
      end
   end

endmodule

// ===== src/rsmf_window.sv =====
`timescale 1ns / 1ps
// rsmf_window: window registers, load position and column/row counters
// depends on rsmf_pkg; drives the next window to the median units
module rsmf_window (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  rsmf_pkg::pixel_type           pix [rsmf_pkg::CHANNELS],
   input  logic [rsmf_pkg::DIM_W-1:0]    width,
   input  logic [rsmf_pkg::DIM_W-1:0]    height,
   output rsmf_pkg::window_type          win_next [rsmf_pkg::CHANNELS],
   output rsmf_pkg::win_status_type      status
);

   rsmf_pkg::window_type            win_ff [rsmf_pkg::CHANNELS];
   logic [rsmf_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [rsmf_pkg::CNT_W-1:0]      col_ff, col_in;
   logic [rsmf_pkg::CNT_W-1:0]      row_ff, row_in;

   logic [rsmf_pkg::POS_W-1:0]      p;
   logic [rsmf_pkg::POS_W-1:0]      p_inc;
   logic                            col_zero;
   logic                            done;
   logic                            last_col;
   logic                            last_row;

   always_comb begin
      col_zero = (col_ff == '0);
      if (col_zero) begin
         p = (pos_ff >= rsmf_pkg::POS_W'(rsmf_pkg::WIN_SIZE)) ? '0 : pos_ff;
      end else begin
         p = (pos_ff >= rsmf_pkg::POS_W'(rsmf_pkg::WINDOW_ROWS)) ? '0 : pos_ff;
      end
      p_inc = p + rsmf_pkg::POS_W'(1);
      done  = col_zero ? (p_inc >= rsmf_pkg::POS_W'(rsmf_pkg::WIN_SIZE))
                       : (p_inc >= rsmf_pkg::POS_W'(rsmf_pkg::WINDOW_ROWS));

      for (int k = 0; k < rsmf_pkg::CHANNELS; k++) begin
         win_next[k] = win_ff[k];
         if (col_zero) begin
            for (int i = 0; i < rsmf_pkg::WIN_SIZE; i++) begin
               if (p == rsmf_pkg::POS_W'(i)) begin
                  win_next[k][i] = pix[k];
               end
            end
         end else begin
            for (int r = 0; r < rsmf_pkg::WINDOW_ROWS; r++) begin
               if (p == rsmf_pkg::POS_W'(r)) begin
                  for (int c = 0; c < rsmf_pkg::WINDOW_COLS - 1; c++) begin
                     win_next[k][r * rsmf_pkg::WINDOW_COLS + c] =
                        win_ff[k][r * rsmf_pkg::WINDOW_COLS + c + 1];
                  end
                  win_next[k][r * rsmf_pkg::WINDOW_COLS + rsmf_pkg::WINDOW_COLS - 1] =
                     pix[k];
               end
            end
         end
      end

      last_col = (({1'b0, col_ff} + rsmf_pkg::DIM_W'(1)) >= width);
      last_row = (({1'b0, row_ff} + rsmf_pkg::DIM_W'(1)) >= height);

      pos_in = p_inc;
      col_in = col_ff;
      row_in = row_ff;
      if (done) begin
         pos_in = '0;
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + rsmf_pkg::CNT_W'(1);
         end else begin
            col_in = col_ff + rsmf_pkg::CNT_W'(1);
         end
      end

      status.done      = done;
      status.frame_end = last_col && last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < rsmf_pkg::CHANNELS; k++) begin
            win_ff[k] <= '0;
         end
         pos_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
      end else if (step) begin
         for (int k = 0; k < rsmf_pkg::CHANNELS; k++) begin
            win_ff[k] <= win_next[k];
         end
         pos_ff <= pos_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule
